### rtl/core/charlieplex_led_and_key_scanner_top_defines.svh
// Assertion macros shared by the scanner RTL.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef CHARLIEPLEX_LED_AND_KEY_SCANNER_TOP_DEFINES_SVH
`define CHARLIEPLEX_LED_AND_KEY_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CLPX_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CLPX_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/clpx_pkg.sv
package clpx_pkg;

	localparam logic [1:0] OP_LED_TICK    = 2'd0;
	localparam logic [1:0] OP_BUTTON_TICK = 2'd1;
	localparam logic [1:0] OP_SET_STEP    = 2'd2;
	localparam logic [1:0] OP_LOAD_MASK   = 2'd3;

	localparam logic [11:0] FULL_MASK          = 12'hfff;
	localparam logic [3:0]  CURRENT_STEP_RESET = 4'd2;
	localparam logic [3:0]  LAST_STEP          = 4'd11;
	localparam logic [2:0]  ROW_COUNT          = 3'd3;
	localparam logic [1:0]  LAST_ROW_CODE      = 2'd3;

	typedef struct packed {
		logic [5:0]  line_enable;
		logic [5:0]  line_level;
		logic [2:0]  row_drive_n;
		logic [11:0] step_mask;
		logic        autosave;
	} clpx_result_t;

	// One-hot line of the first member of each LED's line pair.
	function automatic logic [5:0] pair_first(input logic [3:0] pos);
		logic [5:0] r;
		case (pos)
			4'd0, 4'd1, 4'd2: r = 6'b000001;
			4'd3, 4'd4, 4'd5: r = 6'b000010;
			4'd6, 4'd7, 4'd8: r = 6'b000100;
			4'd9, 4'd10:      r = 6'b001000;
			4'd11:            r = 6'b010000;
			default:          r = 6'b000001;
		endcase
		return r;
	endfunction

	// One-hot line of the second member of each LED's line pair.
	function automatic logic [5:0] pair_second(input logic [3:0] pos);
		logic [5:0] r;
		case (pos)
			4'd0:               r = 6'b000010;
			4'd1, 4'd3:         r = 6'b000100;
			4'd2, 4'd4, 4'd6:   r = 6'b001000;
			4'd5, 4'd7, 4'd9:   r = 6'b010000;
			4'd8, 4'd10, 4'd11: r = 6'b100000;
			default:            r = 6'b000010;
		endcase
		return r;
	endfunction

endpackage

### rtl/core/clpx_scan_core.sv
module clpx_scan_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [1:0]            op,
	input  logic [11:0]           value,
	input  logic [3:0]            column_levels,
	output clpx_pkg::clpx_result_t result
);
	import clpx_pkg::*;

	`include "charlieplex_led_and_key_scanner_top_defines.svh"

	logic [11:0] enabled_mask_q, enabled_mask_d;
	logic [3:0]  current_step_q, current_step_d;
	logic [11:0] pressed_mask_q, pressed_mask_d;
	logic [3:0]  led_position_q, led_position_d;
	logic [1:0]  row_index_q, row_index_d;
	logic [1:0]  column_index_q, column_index_d;
	logic [3:0]  button_index_q, button_index_d;
	logic [5:0]  line_en_q, line_en_d;
	logic [5:0]  line_lv_q, line_lv_d;

	logic [3:0]  pos;
	logic [5:0]  first_line;
	logic [5:0]  second_line;
	logic        pressed;
	logic        pulse;
	logic [2:0]  row_sum;
	logic [1:0]  row_eff;

	always_comb begin
		enabled_mask_d = enabled_mask_q;
		current_step_d = current_step_q;
		pressed_mask_d = pressed_mask_q;
		led_position_d = led_position_q;
		row_index_d    = row_index_q;
		column_index_d = column_index_q;
		button_index_d = button_index_q;
		line_en_d      = line_en_q;
		line_lv_d      = line_lv_q;
		pulse          = 1'b0;
		row_sum        = {1'b0, row_index_q} + 3'd1;

		pos         = (led_position_q > LAST_STEP) ? 4'd0 : led_position_q;
		first_line  = pair_first(pos);
		second_line = pair_second(pos);
		pressed     = ~column_levels[column_index_q];

		case (op)
			OP_LED_TICK: begin
				line_en_d = '0;
				line_lv_d = '0;
				if (pos == current_step_q) begin
					line_en_d = first_line | second_line;
					line_lv_d = first_line;
				end else if (enabled_mask_q[pos]) begin
					line_en_d = first_line | second_line;
					line_lv_d = second_line;
				end
				led_position_d = (pos == LAST_STEP) ? 4'd0 : pos + 4'd1;
			end
			OP_BUTTON_TICK: begin
				if (button_index_q <= LAST_STEP) begin
					if (pressed_mask_q[button_index_q] != pressed) begin
						pressed_mask_d[button_index_q] = pressed;
						if (pressed) begin
							enabled_mask_d[button_index_q] = ~enabled_mask_q[button_index_q];
							pulse = 1'b1;
						end
					end
				end
				button_index_d = button_index_q + 4'd1;
				column_index_d = column_index_q + 2'd1;
				if (column_index_d == 2'd0) begin
					if (row_sum >= ROW_COUNT) begin
						row_index_d    = 2'd0;
						button_index_d = 4'd0;
					end else begin
						row_index_d = row_sum[1:0];
					end
				end
			end
			OP_SET_STEP: begin
				current_step_d = value[3:0];
			end
			OP_LOAD_MASK: begin
				enabled_mask_d = value;
			end
			default: begin
				enabled_mask_d = enabled_mask_q;
			end
		endcase

		row_eff = (row_index_d == LAST_ROW_CODE) ? 2'd0 : row_index_d;

		result.line_enable = line_en_d;
		result.line_level  = line_lv_d;
		result.row_drive_n = ~(3'b001 << row_eff);
		result.step_mask   = enabled_mask_d;
		result.autosave    = pulse;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_mask_q <= FULL_MASK;
			current_step_q <= CURRENT_STEP_RESET;
			pressed_mask_q <= '0;
			led_position_q <= '0;
			row_index_q    <= '0;
			column_index_q <= '0;
			button_index_q <= '0;
			line_en_q      <= '0;
			line_lv_q      <= '0;
		end else if (fire) begin
			enabled_mask_q <= enabled_mask_d;
			current_step_q <= current_step_d;
			pressed_mask_q <= pressed_mask_d;
			led_position_q <= led_position_d;
			row_index_q    <= row_index_d;
			column_index_q <= column_index_d;
			button_index_q <= button_index_d;
			line_en_q      <= line_en_d;
			line_lv_q      <= line_lv_d;
		end
	end

	`CLPX_ASSERT_NOW(a_pulse_only_on_button, pulse, op == OP_BUTTON_TICK,
		"autosave raised outside a button tick")
	`CLPX_ASSERT_NOW(a_led_position_range, 1'b1, led_position_q <= LAST_STEP,
		"LED position left the step range")
	`CLPX_ASSERT_NEXT(a_toggle_changes_mask, fire && pulse,
		enabled_mask_q != $past(enabled_mask_q), "press did not toggle the step mask")
	`CLPX_ASSERT_NOW(a_row_range, 1'b1, row_index_q != LAST_ROW_CODE,
		"key row index reached an unused code")

endmodule

### rtl/core/charlieplex_led_and_key_scanner_top.sv
// Charlieplexed LED and key-matrix scanner. Each input transaction carries one
// operation: an LED tick lights the next of 12 LEDs on 6 charlieplexed lines
// (the current step drives the first line of its pair high and the second low,
// an enabled step the reverse, any other LED floats every line), a button tick
// samples one key of the 3x4 matrix and toggles that step's mask bit on a new
// press while pulsing autosave, and two further operations set the current
// step or load the whole 12-bit mask. Every input transaction yields exactly
// one output transaction holding the latched line drive, the active-low row
// for the next button tick, the mask after the operation and the autosave
// pulse. The block takes one transaction per clock while the output is not
// stalled: an input register feeds a single layer of scan logic that updates
// the state and loads the output register, so a result passes the input
// register and then the output register before it leaves. While a finished
// result waits for out_ready, the input register can still take one
// transaction if it is empty itself; after that in_ready stays low until the
// result is drained. After reset all steps are enabled, the current step is
// two and all LED lines float.
module charlieplex_led_and_key_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [11:0] value,
	input  logic [3:0]  column_levels,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  line_enable,
	output logic [5:0]  line_level,
	output logic [2:0]  row_drive_n,
	output logic [11:0] step_mask,
	output logic        autosave
);
	import clpx_pkg::*;

	`include "charlieplex_led_and_key_scanner_top_defines.svh"

	// Input stage.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [11:0] value_s1;
	logic [3:0]  column_levels_s1;

	// Output stage.
	logic         valid_s2;
	clpx_result_t result_s2;

	clpx_result_t result;
	logic         advance;
	logic         fire;

	// The output register moves when it is empty or being drained; the input
	// register refills whenever its transaction moves on or it is empty.
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1            <= op;
			value_s1         <= value;
			column_levels_s1 <= column_levels;
		end
	end

	// All scan state lives in the scan core and changes only when the staged
	// transaction is handed to the output register.
	clpx_scan_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.op            (op_s1),
		.value         (value_s1),
		.column_levels (column_levels_s1),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign out_valid   = valid_s2;
	assign line_enable = result_s2.line_enable;
	assign line_level  = result_s2.line_level;
	assign row_drive_n = result_s2.row_drive_n;
	assign step_mask   = result_s2.step_mask;
	assign autosave    = result_s2.autosave;

	`CLPX_ASSERT_NEXT(a_stalled_stage_holds, valid_s1 && !advance,
		valid_s1 && $stable(op_s1) && $stable(value_s1), "staged transaction lost in stall")
	`CLPX_ASSERT_NEXT(a_fire_fills_output, fire, valid_s2,
		"processed transaction did not reach the output register")

endmodule

### dv/charlieplex_led_and_key_scanner_top_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the charlieplexed LED and key-matrix scanner.
// Every input transaction yields one output transaction, so the bench keeps
// its own copy of the scan state. It predicts the result of each accepted
// operation and compares the results in order as they leave the block.
module charlieplex_led_and_key_scanner_top_tb;

	import clpx_pkg::*;

	// The run is ended when this many cycles pass with no transaction on either
	// side. It is well above the long receiver hold-off and any random gap.
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned REPORT_LIMIT = 10;

	// The scoreboard holds the predicted scan state and the queue of results
	// that the block still owes.
	class scan_scoreboard;
		int unsigned first_line[12] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 3, 3, 4};
		int unsigned second_line[12] = '{1, 2, 3, 2, 3, 4, 3, 4, 5, 4, 5, 5};
		logic [11:0] enabled_steps;
		logic [3:0] cur_step;
		logic [11:0] held_keys;
		logic [3:0] led_pos;
		logic [1:0] row_idx;
		logic [1:0] col_idx;
		logic [3:0] key_idx;
		logic [5:0] drive_en;
		logic [5:0] drive_lv;
		clpx_result_t expected_scan[$];
		int unsigned mismatches;

		function new();
			enabled_steps = FULL_MASK;
			cur_step = CURRENT_STEP_RESET;
			held_keys = '0;
			led_pos = '0;
			row_idx = '0;
			col_idx = '0;
			key_idx = '0;
			drive_en = '0;
			drive_lv = '0;
			mismatches = 0;
		endfunction

		function void note_accepted_op(logic [1:0] kind, logic [11:0] data, logic [3:0] cols);
			clpx_result_t want;
			logic [3:0] pos;
			logic pressed;
			logic [1:0] row_sel;
			want.autosave = 1'b0;
			case (kind)
				OP_LED_TICK: begin
					pos = (led_pos > LAST_STEP) ? 4'd0 : led_pos;
					drive_en = '0;
					drive_lv = '0;
					if (pos == cur_step) begin
						drive_en = (6'd1 << first_line[pos]) | (6'd1 << second_line[pos]);
						drive_lv = 6'd1 << first_line[pos];
					end else if (enabled_steps[pos]) begin
						drive_en = (6'd1 << first_line[pos]) | (6'd1 << second_line[pos]);
						drive_lv = 6'd1 << second_line[pos];
					end
					led_pos = (pos == LAST_STEP) ? 4'd0 : pos + 4'd1;
				end
				OP_BUTTON_TICK: begin
					pressed = ~cols[col_idx];
					if (key_idx <= LAST_STEP && held_keys[key_idx] != pressed) begin
						held_keys[key_idx] = pressed;
						if (pressed) begin
							enabled_steps[key_idx] = ~enabled_steps[key_idx];
							want.autosave = 1'b1;
						end
					end
					key_idx = key_idx + 4'd1;
					col_idx = col_idx + 2'd1;
					if (col_idx == 2'd0) begin
						if (3'(row_idx) + 3'd1 >= ROW_COUNT) begin
							row_idx = '0;
							key_idx = '0;
						end else begin
							row_idx = row_idx + 2'd1;
						end
					end
				end
				OP_SET_STEP: cur_step = data[3:0];
				default: enabled_steps = data;
			endcase
			row_sel = (3'(row_idx) < ROW_COUNT) ? row_idx : 2'd0;
			want.line_enable = drive_en;
			want.line_level = drive_lv;
			want.row_drive_n = ~(3'b001 << row_sel);
			want.step_mask = enabled_steps;
			expected_scan.push_back(want);
		endfunction

		function void report(string what, clpx_result_t want, clpx_result_t got);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t %s: expected en=%h lv=%h row_n=%b mask=%h save=%b",
					$realtime, what, want.line_enable, want.line_level,
					want.row_drive_n, want.step_mask, want.autosave);
				$display("%0t %s: got      en=%h lv=%h row_n=%b mask=%h save=%b",
					$realtime, what, got.line_enable, got.line_level,
					got.row_drive_n, got.step_mask, got.autosave);
			end
		endfunction

		function void check_scan_result(clpx_result_t got);
			clpx_result_t want;
			if (expected_scan.size() == 0) begin
				report("result with no transaction pending", '0, got);
				return;
			end
			want = expected_scan.pop_front();
			if (got.line_enable !== want.line_enable || got.line_level !== want.line_level ||
					got.row_drive_n !== want.row_drive_n || got.step_mask !== want.step_mask ||
					got.autosave !== want.autosave)
				report("result mismatch", want, got);
		endfunction

		function int unsigned pending();
			return expected_scan.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic [11:0] value;
	logic [3:0] column_levels;
	logic out_valid;
	logic out_ready;
	logic [5:0] line_enable;
	logic [5:0] line_level;
	logic [2:0] row_drive_n;
	logic [11:0] step_mask;
	logic autosave;

	scan_scoreboard scan_check = new();

	// Idle rates in percent; the main sequence changes them between phases.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// When set, the receiver holds off for this many cycles, counting them down itself.
	int unsigned hold_cycles = 0;
	int unsigned quiet_cycles = 0;
	// Column pattern that is held across several button ticks, so that keys stay
	// pressed over whole scans and are later released.
	logic [3:0] held_cols = 4'hf;

	charlieplex_led_and_key_scanner_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.op(op),
		.value(value),
		.column_levels(column_levels),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.line_enable(line_enable),
		.line_level(line_level),
		.row_drive_n(row_drive_n),
		.step_mask(step_mask),
		.autosave(autosave)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one input transaction, after a random number of idle cycles, and hold
	// it until it is accepted. The caller always stands at a rising edge, so the
	// valid line gets only one assignment per edge.
	task automatic send_item(input logic [1:0] kind, input logic [11:0] data,
			input logic [3:0] cols);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= kind;
		value <= data;
		column_levels <= cols;
		do @(posedge clk); while (!in_ready);
		scan_check.note_accepted_op(kind, data, cols);
	endtask

	// Stop offering transactions until the block has returned every result.
	// The task always waits on the clock before it returns, so valid is never
	// lowered and raised in the same step.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (scan_check.pending() != 0);
	endtask

	// Button ticks dominate, since only they reach the press and release logic.
	// Their column levels are random, all released, or a pattern held for a while.
	task automatic send_random_op();
		int unsigned pick;
		logic [1:0] kind;
		logic [11:0] data;
		logic [3:0] cols;
		pick = $urandom_range(99);
		data = 12'($urandom);
		cols = 4'($urandom);
		if (pick < 35) begin
			kind = OP_LED_TICK;
		end else if (pick < 80) begin
			kind = OP_BUTTON_TICK;
			case ($urandom_range(3))
				0: cols = 4'hf;
				1, 2: cols = held_cols;
				default: ;
			endcase
		end else if (pick < 90) begin
			kind = OP_SET_STEP;
		end else begin
			kind = OP_LOAD_MASK;
			case ($urandom_range(3))
				0: data = '0;
				1: data = FULL_MASK;
				2: data = 12'(1) << $urandom_range(11);
				default: ;
			endcase
		end
		if ($urandom_range(19) == 0)
			held_cols = 4'($urandom);
		send_item(kind, data, cols);
	endtask

	// The receiver samples before its own update at each edge, then decides on
	// the ready for the next cycle: a pending hold-off wins over random stalls.
	initial begin
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				scan_check.check_scan_result(clpx_result_t'({line_enable, line_level,
					row_drive_n, step_mask, autosave}));
			if (hold_cycles > 0) begin
				out_ready <= 1'b0;
				hold_cycles--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles with no transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LED_TICK;
		value = '0;
		column_levels = 4'hf;
		out_ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, with no idling. A button tick first shows the lines
		// floating after reset. An alternating mask with the current step at five
		// then lets one full LED scan show both colors, dark LEDs and the wrap of
		// the position. The upper bits of a set-step value must be dropped.
		send_item(OP_BUTTON_TICK, 12'h000, 4'hf);
		send_item(OP_LOAD_MASK, 12'haaa, 4'h0);
		send_item(OP_SET_STEP, 12'hff5, 4'h0);
		repeat (12) send_item(OP_LED_TICK, 12'h000, 4'h0);
		// A current step of fifteen matches no LED, so nothing shows the first color.
		send_item(OP_SET_STEP, 12'hfff, 4'hf);
		repeat (2) send_item(OP_LED_TICK, 12'hfff, 4'hf);
		send_item(OP_LOAD_MASK, 12'h000, 4'h0);
		// Fresh presses toggle and pulse autosave. A released key neither toggles
		// nor pulses, and a later press on the next key toggles again.
		repeat (3) send_item(OP_BUTTON_TICK, 12'hfff, 4'h0);
		send_item(OP_BUTTON_TICK, 12'h000, 4'hf);
		send_item(OP_LOAD_MASK, FULL_MASK, 4'hf);
		send_item(OP_BUTTON_TICK, 12'h000, 4'h0);

		// No idling. The receiver holds off for a long stretch while the sender
		// keeps offering, so the block fills up and stalls its input.
		hold_cycles = HOLD_OFF_CYCLES;
		repeat (380) send_random_op();
		wait_for_drain();

		// The sender idles most of the time.
		send_idle_pct = 67;
		recv_stall_pct = 0;
		repeat (380) send_random_op();
		wait_for_drain();

		// The receiver stalls most of the time.
		send_idle_pct = 0;
		recv_stall_pct = 67;
		repeat (380) send_random_op();
		wait_for_drain();

		// Both sides idle a third of the time.
		send_idle_pct = 33;
		recv_stall_pct = 33;
		repeat (385) send_random_op();
		wait_for_drain();

		// Wait on to catch a stray result that leaves after the drain.
		repeat (8) @(posedge clk);
		if (scan_check.mismatches == 0 && scan_check.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/clpx_pkg.sv
rtl/core/clpx_scan_core.sv
rtl/core/charlieplex_led_and_key_scanner_top.sv
dv/charlieplex_led_and_key_scanner_top_tb.sv
